// ===== sv/stb_pkg.sv =====
// ============================================================================
// stb_pkg: shared types and constants of the software timer bank
// Item structs for the command and result channels, command codes and the
// layout of one timer entry as kept in the entry memory.
// ============================================================================
`default_nettype none

package stb_pkg;

    // Number of timers in the bank (1 to 256).
    localparam int NUM_TIMERS = 16;
    // Bits of an entry index.
    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    // Command codes; codes 6 and 7 act as a query.
    localparam logic [2:0] CMD_ADD       = 3'd0;
    localparam logic [2:0] CMD_ADD_START = 3'd1;
    localparam logic [2:0] CMD_START     = 3'd2;
    localparam logic [2:0] CMD_STOP      = 3'd3;
    localparam logic [2:0] CMD_UPDATE    = 3'd4;
    localparam logic [2:0] CMD_QUERY     = 3'd5;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  timer_id;
        logic [31:0] interval_ms;
        logic        cyclic;
        logic [31:0] now_ms;
    } stb_in_t;

    typedef struct packed {
        logic        valid_res;
        logic        is_active;
        logic        is_done;
        logic [31:0] elapsed_ms;
        logic [31:0] remaining_ms;
    } stb_out_t;

    // One timer entry of the entry memory.
    typedef struct packed {
        logic [31:0] start_time;
        logic [31:0] interval_len;
        logic        running;
        logic        expired;
        logic        repeats;
    } stb_entry_t;

endpackage

`default_nettype wire

// ===== sv/software_timer_bank.sv =====
// ============================================================================
// software_timer_bank: bank of millisecond software timers
// Add, start, stop, update and query timers addressed by id, one command
// item at a time, with one status result per item.
// ============================================================================
// A command item is taken when start is high and busy is low. Exactly one
// result item follows for every command: it sits on result for one cycle with
// result_strobe high and cannot be held off, so the receiver must take it
// then. The result reports the addressed timer after the command has acted.
// For add, start, stop and query items, S_RESP registers the result and
// its strobe after acceptance. Busy is low again during the strobe cycle,
// so the next such item can be taken while the result is shown. An
// update item walks the entry memory through its single read port, one timer
// per cycle, in S_SWEEP, then passes S_DRAIN, S_READ and S_RESP before its
// strobe rises; busy stays high until then.
// The initialized marks are cleared by reset at once; no clearing pass runs,
// and the block takes items right after reset.
`default_nettype none

module software_timer_bank (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire stb_pkg::stb_in_t request,
    output stb_pkg::stb_out_t    result,
    output logic                 result_strobe
);

    localparam logic [stb_pkg::IDX_W-1:0] LAST_IDX = stb_pkg::IDX_W'(stb_pkg::NUM_TIMERS - 1);
    localparam logic [8:0] NUM_IDS = 9'(stb_pkg::NUM_TIMERS);

    // S_SWEEP reads one entry per cycle and writes back the one read before;
    // S_DRAIN finishes the last entry; S_READ fetches the reported entry;
    // S_RESP applies a single-entry command and forms the result.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_DRAIN,
        S_READ,
        S_RESP
    } state_t;

    state_t                      state_reg, state_next;
    stb_pkg::stb_in_t            req_reg;
    logic [stb_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic                        pend_reg, pend_next;
    logic [stb_pkg::IDX_W-1:0]   pend_idx_reg;
    logic [stb_pkg::NUM_TIMERS-1:0] in_use_reg, in_use_next;
    stb_pkg::stb_out_t           res_reg, res_next;
    logic                        strobe_reg, strobe_next;

    // Entry memory: one write port, one registered read port.
    stb_pkg::stb_entry_t         mem [stb_pkg::NUM_TIMERS];
    stb_pkg::stb_entry_t         rd_data_reg;
    logic [stb_pkg::IDX_W-1:0]   rd_addr;
    logic                        wr_en;
    logic [stb_pkg::IDX_W-1:0]   wr_addr;
    stb_pkg::stb_entry_t         wr_data;

    logic [stb_pkg::IDX_W-1:0]   req_idx;
    logic                        req_in_range;
    logic                        req_in_use;
    stb_pkg::stb_entry_t         sweep_entry;
    logic                        sweep_wr;
    stb_pkg::stb_entry_t         resp_entry;
    logic                        resp_wr;
    logic                        resp_use;
    logic                        resp_valid;
    logic [31:0]                 elapsed;

    assign busy          = (state_reg != S_IDLE);
    assign result        = res_reg;
    assign result_strobe = strobe_reg;

    assign req_idx      = req_reg.timer_id[stb_pkg::IDX_W-1:0];
    assign req_in_range = ({1'b0, req_reg.timer_id} < NUM_IDS);
    assign req_in_use   = in_use_reg[req_idx];

    // Read address: the incoming id on acceptance, the walk index while
    // sweeping, the held id otherwise.
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  rd_addr = request.timer_id[stb_pkg::IDX_W-1:0];
            S_SWEEP: rd_addr = idx_reg;
            default: rd_addr = req_idx;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Update of one entry during the walk: re-arm a done cyclic timer,
    // otherwise mark it done once its interval has run out.
    always_comb
    begin
        sweep_entry = rd_data_reg;
        sweep_wr    = 1'b0;
        if (in_use_reg[pend_idx_reg] && rd_data_reg.running)
        begin
            if (rd_data_reg.expired)
            begin
                if (rd_data_reg.repeats)
                begin
                    sweep_entry.expired    = 1'b0;
                    sweep_entry.start_time = req_reg.now_ms;
                    sweep_wr               = 1'b1;
                end
            end
            else if ((req_reg.now_ms - rd_data_reg.start_time) >= rd_data_reg.interval_len)
            begin
                sweep_entry.expired = 1'b1;
                sweep_wr            = 1'b1;
            end
        end
    end

    // Single-entry commands on the addressed timer.
    always_comb
    begin
        resp_entry = rd_data_reg;
        resp_wr    = 1'b0;
        resp_use   = req_in_use;
        if (req_in_range && (req_reg.command != stb_pkg::CMD_UPDATE))
        begin
            if ((req_reg.command == stb_pkg::CMD_ADD)
                || (req_reg.command == stb_pkg::CMD_ADD_START))
            begin
                resp_entry.start_time   = '0;
                resp_entry.interval_len = '0;
                resp_entry.running      = 1'b0;
                resp_entry.expired      = 1'b0;
                resp_entry.repeats      = req_reg.cyclic;
                resp_use                = 1'b1;
                resp_wr                 = 1'b1;
                if (req_reg.command == stb_pkg::CMD_ADD_START)
                begin
                    resp_entry.start_time   = req_reg.now_ms;
                    resp_entry.interval_len = req_reg.interval_ms;
                    resp_entry.running      = 1'b1;
                end
            end
            else if ((req_reg.command == stb_pkg::CMD_START) && req_in_use)
            begin
                resp_entry.start_time   = req_reg.now_ms;
                resp_entry.interval_len = req_reg.interval_ms;
                resp_entry.running      = 1'b1;
                resp_entry.expired      = 1'b0;
                resp_wr                 = 1'b1;
            end
            else if ((req_reg.command == stb_pkg::CMD_STOP) && req_in_use)
            begin
                resp_entry.start_time   = '0;
                resp_entry.interval_len = '0;
                resp_entry.running      = 1'b0;
                resp_entry.expired      = 1'b0;
                resp_wr                 = 1'b1;
            end
        end
    end

    assign resp_valid = req_in_range && resp_use;
    assign elapsed    = req_reg.now_ms - resp_entry.start_time;

    // Write port: walk write-back, or the single-entry command.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pend_idx_reg;
        wr_data = sweep_entry;
        if (((state_reg == S_SWEEP) || (state_reg == S_DRAIN)) && pend_reg)
        begin
            wr_en = sweep_wr;
        end
        else if (state_reg == S_RESP)
        begin
            wr_en   = resp_wr;
            wr_addr = req_idx;
            wr_data = resp_entry;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        pend_next   = pend_reg;
        in_use_next = in_use_reg;
        res_next    = res_reg;
        strobe_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    idx_next  = '0;
                    pend_next = 1'b0;
                    if (request.command == stb_pkg::CMD_UPDATE)
                    begin
                        state_next = S_SWEEP;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_SWEEP:
            begin
                pend_next = 1'b1;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                pend_next  = 1'b0;
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (resp_wr)
                begin
                    in_use_next[req_idx] = 1'b1;
                end
                res_next.valid_res    = resp_valid;
                res_next.is_active    = resp_valid && resp_entry.running;
                res_next.is_done      = resp_valid && resp_entry.expired;
                res_next.elapsed_ms   = '0;
                res_next.remaining_ms = '0;
                if (resp_valid && resp_entry.running)
                begin
                    res_next.elapsed_ms = elapsed;
                    if (elapsed < resp_entry.interval_len)
                    begin
                        res_next.remaining_ms = resp_entry.interval_len - elapsed;
                    end
                end
                strobe_next = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            pend_reg   <= 1'b0;
            in_use_reg <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            pend_reg   <= pend_next;
            in_use_reg <= in_use_next;
            strobe_reg <= strobe_next;
        end
    end

    // Payload registers: hold the item and the pipeline index, no reset.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && start)
        begin
            req_reg <= request;
        end
        if (state_reg == S_SWEEP)
        begin
            pend_idx_reg <= idx_reg;
        end
        res_reg <= res_next;
    end

    // A result only follows the response step.
    a_strobe_after_resp: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(state_reg == S_RESP))
        else $error("result strobe without a response step");

    // No walk write-back may be left pending once the block is idle.
    a_no_pend_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!pend_reg && !wr_en))
        else $error("entry memory written while idle");

    // The walk advances one entry per cycle.
    a_walk_advances: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SWEEP) && (idx_reg != LAST_IDX))
        |=> ((state_reg == S_SWEEP) && (idx_reg == $past(idx_reg) + 1'b1)))
        else $error("timer walk skipped or stalled");

    // Initialized marks are only set, by a response step.
    a_in_use_set_only: assert property (@(posedge clk) disable iff (!rst_n)
        (in_use_reg != $past(in_use_reg)) |-> $past(state_reg == S_RESP))
        else $error("initialized marks changed outside a response step");

endmodule

`default_nettype wire
